### sv/mspc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mspc_pkg: shared types and constants of the motor speed controller
// Widths, fixed-point constants, register indexes and the command and status
// bundles that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package mspc_pkg;

	// Field and state widths
	localparam int TIMER_BITS  = 16;
	localparam int RPM_BITS    = 12;
	localparam int EDGE_BITS   = 16;
	localparam int DUTY_BITS   = 15;
	localparam int TARGET_BITS = 9;
	localparam int SAMPLE_BITS = 10;
	localparam int CMP_BITS    = 10;
	localparam int CFG_BITS    = 16;
	localparam int INDEX_BITS  = 3;

	// Speed estimate: ticks per minute divided by ticks per window
	localparam int unsigned TICKS_PER_MINUTE = 937500;
	localparam int DIV_BITS = $clog2(TICKS_PER_MINUTE + 1);
	localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
	localparam logic [DIV_BITS-1:0] DIVIDEND = DIV_BITS'(TICKS_PER_MINUTE);
	localparam logic [RPM_BITS-1:0] RPM_MAX = {RPM_BITS{1'b1}};

	// Knob sample divided by 51 as multiply by 5141 / 2^18 (exact for 10 bits)
	localparam int KNOB_RECIP_BITS = 13;
	localparam logic [KNOB_RECIP_BITS-1:0] KNOB_RECIP = 13'd5141;
	localparam int KNOB_SHIFT = 18;
	localparam int KNOB_Q_BITS = 5;

	// Duty arithmetic in 1/256 percent
	localparam int ERR_BITS  = RPM_BITS + 1;
	localparam int GAIN_BITS = 8;
	localparam int PROD_BITS = ERR_BITS + GAIN_BITS + 1;
	localparam int DSUM_BITS = PROD_BITS + 1;
	localparam logic [DUTY_BITS-1:0] FULL_DUTY_Q8  = 15'd25600;
	localparam logic [DUTY_BITS-1:0] RESET_DUTY_Q8 = 15'd11520;

	// Register indexes
	localparam logic [INDEX_BITS-1:0] REG_WINDOW_EDGES = 3'd0;
	localparam logic [INDEX_BITS-1:0] REG_GAIN_Q8      = 3'd1;
	localparam logic [INDEX_BITS-1:0] REG_DUTY_FLOOR   = 3'd2;
	localparam logic [INDEX_BITS-1:0] REG_DUTY_CEILING = 3'd3;
	localparam logic [INDEX_BITS-1:0] REG_TARGET_BASE  = 3'd4;
	localparam logic [INDEX_BITS-1:0] REG_LOW_LEVEL    = 3'd5;
	localparam logic [INDEX_BITS-1:0] REG_HIGH_LEVEL   = 3'd6;

	// Register file contents
	typedef struct packed {
		logic [EDGE_BITS-1:0]   window_edges;
		logic [GAIN_BITS-1:0]   gain_q8;
		logic [6:0]             duty_floor;
		logic [6:0]             duty_ceiling;
		logic [7:0]             target_base;
		logic [SAMPLE_BITS-1:0] low_level;
		logic [SAMPLE_BITS-1:0] high_level;
	} cfg_t;

	// Sequencer to datapath
	typedef struct packed {
		logic tick;      // take the input transaction, advance counters
		logic div_step;  // one quotient bit of the speed divider
		logic mul;       // form the gain times speed error product
		logic update;    // commit the window close
		logic load_out;  // load the result register
	} cmd_t;

	// Datapath to sequencer
	typedef struct packed {
		logic closed;
	} status_t;

endpackage
`default_nettype wire

### sv/mspc_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mspc_cfg_regs: configuration register file
// Seven write-only registers; writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module mspc_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [mspc_pkg::INDEX_BITS-1:0]  cfg_index,
	input  wire logic [mspc_pkg::CFG_BITS-1:0]    cfg_data,
	output      mspc_pkg::cfg_t                   cfg
);

	mspc_pkg::cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_edges <= 16'd1120;
			cfg_q.gain_q8      <= 8'd77;
			cfg_q.duty_floor   <= 7'd33;
			cfg_q.duty_ceiling <= 7'd70;
			cfg_q.target_base  <= 8'd100;
			cfg_q.low_level    <= 10'd10;
			cfg_q.high_level   <= 10'd800;
		end else if (cfg_we) begin
			case (cfg_index)
				mspc_pkg::REG_WINDOW_EDGES: cfg_q.window_edges <= cfg_data;
				mspc_pkg::REG_GAIN_Q8:      cfg_q.gain_q8      <= cfg_data[7:0];
				mspc_pkg::REG_DUTY_FLOOR:   cfg_q.duty_floor   <= cfg_data[6:0];
				mspc_pkg::REG_DUTY_CEILING: cfg_q.duty_ceiling <= cfg_data[6:0];
				mspc_pkg::REG_TARGET_BASE:  cfg_q.target_base  <= cfg_data[7:0];
				mspc_pkg::REG_LOW_LEVEL:    cfg_q.low_level    <= cfg_data[9:0];
				mspc_pkg::REG_HIGH_LEVEL:   cfg_q.high_level   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### sv/mspc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mspc_ctrl: sequencer of the speed controller
// Takes one tick transaction at a time, runs the divider and the duty update
// on a window close, and owns the result valid flag.
// ----------------------------------------------------------------------------
module mspc_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output      logic         in_stall,
	output      logic         out_valid,
	input  wire logic         out_stall,
	input  wire mspc_pkg::status_t st,
	output      mspc_pkg::cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CHK  = 6'b000010,
		S_DIV  = 6'b000100,
		S_MUL  = 6'b001000,
		S_UPD  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [mspc_pkg::DIV_CNT_BITS-1:0] div_cnt_q;
	logic out_valid_q;
	logic out_free;
	logic div_last;

	assign out_free = !out_valid_q || !out_stall;
	assign div_last = (div_cnt_q == mspc_pkg::DIV_CNT_BITS'(mspc_pkg::DIV_BITS - 1));
	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.tick = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				state_d = st.closed ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_last) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Count divider steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (state_q == S_CHK) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// Hold result valid until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### sv/mspc_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mspc_dpath: datapath of the speed controller
// Edge counter, tick timer, restoring speed divider, duty update with clamp,
// threshold indicators and the result register.
// ----------------------------------------------------------------------------
module mspc_dpath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mspc_pkg::cfg_t                    cfg,
	input  wire mspc_pkg::cmd_t                    cmd,
	output      mspc_pkg::status_t                 st,
	input  wire logic [1:0]                        edge_count,
	input  wire logic [mspc_pkg::SAMPLE_BITS-1:0]  knob_sample,
	output      logic [mspc_pkg::CMP_BITS-1:0]     compare_value,
	output      logic                              window_closed,
	output      logic [mspc_pkg::RPM_BITS-1:0]     measured_rpm,
	output      logic [mspc_pkg::TARGET_BITS-1:0]  target_rate,
	output      logic                              low_indicator,
	output      logic                              high_indicator
);

	localparam int TB = mspc_pkg::TIMER_BITS;
	localparam int RB = mspc_pkg::RPM_BITS;
	localparam int DB = mspc_pkg::DIV_BITS;
	localparam int KP = mspc_pkg::SAMPLE_BITS + mspc_pkg::KNOB_RECIP_BITS;

	// State registers
	logic [mspc_pkg::EDGE_BITS-1:0]   edge_cnt_q;
	logic [TB-1:0]                    timer_q;
	logic [mspc_pkg::DUTY_BITS-1:0]   duty_q;
	logic [RB-1:0]                    rpm_latest_q;
	logic [RB-1:0]                    rpm_used_q;
	logic [mspc_pkg::SAMPLE_BITS-1:0] prev_sample_q;
	logic                             low_flag_q;
	logic                             high_flag_q;
	logic [mspc_pkg::TARGET_BITS-1:0] target_q;
	logic                             closed_q;

	// Working registers of one transaction
	logic [mspc_pkg::SAMPLE_BITS-1:0] sample_q;
	logic [mspc_pkg::KNOB_Q_BITS-1:0] knob_q;
	logic [TB-1:0]                    rem_q;
	logic [DB-1:0]                    quo_q;
	logic signed [mspc_pkg::PROD_BITS-1:0] prod_q;

	// Result register
	logic [mspc_pkg::CMP_BITS-1:0]    cmp_out_q;
	logic                             closed_out_q;
	logic [RB-1:0]                    rpm_out_q;
	logic [mspc_pkg::TARGET_BITS-1:0] target_out_q;
	logic                             low_out_q;
	logic                             high_out_q;

	// Tick arithmetic
	logic [mspc_pkg::EDGE_BITS:0]     edge_sum;
	logic [mspc_pkg::EDGE_BITS-1:0]   edge_next;
	logic [TB-1:0]                    timer_next;
	logic                             wrap;
	logic [KP-1:0]                    knob_prod;

	assign edge_sum   = {1'b0, edge_cnt_q} + {{(mspc_pkg::EDGE_BITS - 1){1'b0}}, edge_count};
	assign edge_next  = edge_sum[mspc_pkg::EDGE_BITS] ? {mspc_pkg::EDGE_BITS{1'b1}}
	                                                  : edge_sum[mspc_pkg::EDGE_BITS-1:0];
	assign timer_next = timer_q + 1'b1;
	assign wrap       = (timer_next == '0);
	assign knob_prod  = KP'(knob_sample) * KP'(mspc_pkg::KNOB_RECIP);

	// Divider step: shift in one dividend bit, subtract when it fits
	logic [TB:0] rem_sh;
	logic        fits;
	assign rem_sh = {rem_q, quo_q[DB-1]};
	assign fits   = (rem_sh >= {1'b0, timer_q});

	// Saturated speed and new target
	logic [RB-1:0]                    rpm_sat;
	logic [mspc_pkg::TARGET_BITS-1:0] target_next;
	assign rpm_sat     = (|quo_q[DB-1:RB]) ? mspc_pkg::RPM_MAX : quo_q[RB-1:0];
	assign target_next = {1'b0, cfg.target_base}
	                   + {{(mspc_pkg::TARGET_BITS - mspc_pkg::KNOB_Q_BITS){1'b0}}, knob_q};

	// Speed error times gain
	logic signed [mspc_pkg::ERR_BITS-1:0] err;
	assign err = signed'({{(mspc_pkg::ERR_BITS - mspc_pkg::TARGET_BITS){1'b0}}, target_next})
	           - signed'({1'b0, rpm_used_q});

	// Duty sum and clamp, floor first and ceiling last
	logic signed [mspc_pkg::DSUM_BITS-1:0] dsum, lo, hi, dclamp;
	always_comb begin
		dsum = signed'({{(mspc_pkg::DSUM_BITS - mspc_pkg::DUTY_BITS){1'b0}}, duty_q})
		     + signed'({prod_q[mspc_pkg::PROD_BITS-1], prod_q});
		lo = signed'({{(mspc_pkg::DSUM_BITS - mspc_pkg::DUTY_BITS){1'b0}},
		              cfg.duty_floor, 8'b0});
		hi = signed'({{(mspc_pkg::DSUM_BITS - mspc_pkg::DUTY_BITS){1'b0}},
		              cfg.duty_ceiling, 8'b0});
		dclamp = dsum;
		if (dclamp < lo) dclamp = lo;
		if (dclamp > hi) dclamp = hi;
	end

	// Indicator crossings
	logic low_next, high_next;
	always_comb begin
		low_next = low_flag_q;
		if (sample_q < cfg.low_level && prev_sample_q > cfg.low_level) low_next = 1'b1;
		else if (sample_q > cfg.low_level) low_next = 1'b0;
		high_next = high_flag_q;
		if (sample_q > cfg.high_level && prev_sample_q < cfg.high_level) high_next = 1'b1;
		else if (sample_q < cfg.high_level) high_next = 1'b0;
	end

	// Compare value: duty capped at full scale, times ten, over 256
	logic [mspc_pkg::DUTY_BITS-1:0] duty_cap;
	logic [mspc_pkg::DUTY_BITS+3:0] duty_x10;
	assign duty_cap = (duty_q > mspc_pkg::FULL_DUTY_Q8) ? mspc_pkg::FULL_DUTY_Q8 : duty_q;
	assign duty_x10 = ({4'b0, duty_cap} << 3) + ({4'b0, duty_cap} << 1);

	// Update controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cnt_q    <= '0;
			timer_q       <= '0;
			duty_q        <= mspc_pkg::RESET_DUTY_Q8;
			rpm_latest_q  <= '0;
			rpm_used_q    <= '0;
			prev_sample_q <= '0;
			low_flag_q    <= 1'b0;
			high_flag_q   <= 1'b0;
			target_q      <= '0;
			closed_q      <= 1'b0;
		end else if (cmd.tick) begin
			edge_cnt_q <= edge_next;
			timer_q    <= timer_next;
			if (wrap) rpm_latest_q <= '0;
			rpm_used_q <= wrap ? '0 : rpm_latest_q;
			closed_q   <= (edge_next >= cfg.window_edges);
		end else if (cmd.update) begin
			edge_cnt_q    <= '0;
			timer_q       <= '0;
			duty_q        <= dclamp[mspc_pkg::DUTY_BITS-1:0];
			rpm_latest_q  <= rpm_sat;
			target_q      <= target_next;
			prev_sample_q <= sample_q;
			low_flag_q    <= low_next;
			high_flag_q   <= high_next;
		end
	end

	// Capture the transaction and start the divider
	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			sample_q <= knob_sample;
			knob_q   <= knob_prod[mspc_pkg::KNOB_SHIFT +: mspc_pkg::KNOB_Q_BITS];
			rem_q    <= '0;
			quo_q    <= mspc_pkg::DIVIDEND;
		end else if (cmd.div_step) begin
			rem_q <= fits ? TB'(rem_sh - {1'b0, timer_q}) : rem_sh[TB-1:0];
			quo_q <= {quo_q[DB-2:0], fits};
		end
		if (cmd.mul) begin
			prod_q <= err * signed'({1'b0, cfg.gain_q8});
		end
	end

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_out_q    <= '0;
			closed_out_q <= 1'b0;
			rpm_out_q    <= '0;
			target_out_q <= '0;
			low_out_q    <= 1'b0;
			high_out_q   <= 1'b0;
		end else if (cmd.load_out) begin
			cmp_out_q    <= duty_x10[mspc_pkg::CMP_BITS+7:8];
			closed_out_q <= closed_q;
			rpm_out_q    <= rpm_latest_q;
			target_out_q <= target_q;
			low_out_q    <= low_flag_q;
			high_out_q   <= high_flag_q;
		end
	end

	assign st.closed      = closed_q;
	assign compare_value  = cmp_out_q;
	assign window_closed  = closed_out_q;
	assign measured_rpm   = rpm_out_q;
	assign target_rate    = target_out_q;
	assign low_indicator  = low_out_q;
	assign high_indicator = high_out_q;

endmodule
`default_nettype wire

### sv/motor_speed_p_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// motor_speed_p_controller: proportional motor speed controller
// Counts encoder edges per timer tick, estimates speed once per window and
// steers the PWM duty toward a knob-set target.
// ----------------------------------------------------------------------------
// One input transaction per timer tick gives one result transaction. A tick
// that does not close a window goes through the check state to the result
// register; a tick that closes a window also runs the bit-serial restoring
// divider that forms 937500 / ticks, then the multiply and duty update. A new
// tick is accepted once the previous one has been moved into the result
// register, even while that result still waits to be taken. Configuration
// writes take effect at once and belong in idle periods only.
module motor_speed_p_controller (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic [1:0]                        edge_count,
	input  wire logic [mspc_pkg::SAMPLE_BITS-1:0]  knob_sample,
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic [mspc_pkg::CMP_BITS-1:0]     compare_value,
	output      logic                              window_closed,
	output      logic [mspc_pkg::RPM_BITS-1:0]     measured_rpm,
	output      logic [mspc_pkg::TARGET_BITS-1:0]  target_rate,
	output      logic                              low_indicator,
	output      logic                              high_indicator,
	input  wire logic                              cfg_we,
	input  wire logic [mspc_pkg::INDEX_BITS-1:0]   cfg_index,
	input  wire logic [mspc_pkg::CFG_BITS-1:0]     cfg_data
);

	mspc_pkg::cfg_t    cfg;
	mspc_pkg::cmd_t    cmd;
	mspc_pkg::status_t st;

	mspc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mspc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	mspc_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.st             (st),
		.edge_count     (edge_count),
		.knob_sample    (knob_sample),
		.compare_value  (compare_value),
		.window_closed  (window_closed),
		.measured_rpm   (measured_rpm),
		.target_rate    (target_rate),
		.low_indicator  (low_indicator),
		.high_indicator (high_indicator)
	);

	// An accepted tick keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted again right after a tick");

	// A result appears only after a tick was in progress
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a tick in progress");

	// Without a window close the target and indicators carry over
	a_hold_without_close: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && !st.closed) |=>
			(target_rate == $past(target_rate) && low_indicator == $past(low_indicator)
			 && high_indicator == $past(high_indicator)))
		else $error("target or indicator changed without a window close");

endmodule
`default_nettype wire
